// ===== src/rcf_pkg.sv =====
// Shared types and constants for the rectangle and circle fill engine.
package rcf_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_RECT   = 2'd0,
    FUNC_CIRCLE = 2'd1,
    FUNC_STEP   = 2'd2,
    FUNC_STEP_X = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd4;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BE_W    = 4;
  localparam int unsigned SCR_W   = 13;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned RSQ_W   = 30;

  localparam logic       FMT_32BPP = 1'b0;
  localparam logic [3:0] BE_32BPP  = 4'hF;
  localparam logic [3:0] BE_24BPP  = 4'h7;

  // One scan position handed from the scan stage to the pixel stage.
  typedef struct packed {
    logic                     cand;    // busy step: position may be written
    logic                     done;    // shape finished or empty, or engine idle
    logic                     circle;
    logic [SCR_W-1:0]         col;
    logic [SCR_W-1:0]         row;
    logic signed [OFS_W-1:0]  dx;
    logic signed [OFS_W-1:0]  dy;
    logic [RSQ_W-1:0]         rsq;
    logic [DATA_W-1:0]        color;
  } job_t;

  // Configuration seen by the pixel stage.
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [PITCH_W-1:0] pitch;
    logic               fmt;
  } pix_cfg_t;

  // One result item.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [BE_W-1:0]   be;
    logic              done;
  } result_t;

endpackage

// ===== src/rcf_pixel_calc.sv =====
// Pixel stage logic: circle membership test and framebuffer address.
module rcf_pixel_calc (
  input  rcf_pkg::job_t     job_i,
  input  rcf_pkg::pix_cfg_t cfg_i,
  output rcf_pkg::result_t  res_o
);
  import rcf_pkg::*;

  logic signed [31:0] dx_sq;
  logic signed [31:0] dy_sq;
  logic [31:0]        dist_sq;
  logic               keep;
  logic [28:0]        row_ofs;
  logic [SCR_W+1:0]   col_ofs;
  logic [ADDR_W-1:0]  addr;

  // Offsets are bounded by the radius, so each square fits in 31 bits.
  assign dx_sq   = {{(32-OFS_W){job_i.dx[OFS_W-1]}}, job_i.dx}
                 * {{(32-OFS_W){job_i.dx[OFS_W-1]}}, job_i.dx};
  assign dy_sq   = {{(32-OFS_W){job_i.dy[OFS_W-1]}}, job_i.dy}
                 * {{(32-OFS_W){job_i.dy[OFS_W-1]}}, job_i.dy};
  assign dist_sq = {1'b0, dx_sq[30:0]} + {1'b0, dy_sq[30:0]};
  assign keep    = job_i.cand && (!job_i.circle || (dist_sq <= {2'b00, job_i.rsq}));

  // base + row * pitch + col * bytes per pixel
  assign row_ofs = {16'd0, job_i.row} * {13'd0, cfg_i.pitch};
  assign col_ofs = (cfg_i.fmt == FMT_32BPP) ? {job_i.col, 2'b00}
                                            : ({1'b0, job_i.col, 1'b0} + {2'b00, job_i.col});
  assign addr    = cfg_i.base + {{(ADDR_W-29){1'b0}}, row_ofs}
                                + {{(ADDR_W-SCR_W-2){1'b0}}, col_ofs};

  always_comb begin
    res_o      = '0;
    res_o.done = job_i.done;
    if (keep) begin
      res_o.we   = 1'b1;
      res_o.addr = addr;
      if (cfg_i.fmt == FMT_32BPP) begin
        res_o.data = job_i.color;
        res_o.be   = BE_32BPP;
      end else begin
        res_o.data = {8'h00, job_i.color[23:0]};
        res_o.be   = BE_24BPP;
      end
    end
  end

endmodule

// ===== src/rect_circle_fill_engine.sv =====
// Top level of the rectangle and circle fill engine: scan state and handshakes.
//
// Usage: a start item (tuser func = rectangle or circle) loads the shape and its
// color and clips its bounding box to the screen; each step item then visits one
// position of that box, row by row, left to right. Every input item gives exactly
// one result item. A kept pixel gives a write (m_axis_tuser = 1) with byte
// address, data and byte enables in m_axis_tdata; m_axis_tlast flags the last
// position of a shape, an empty shape or a step while idle.
// Configuration goes through the cfg channel, always ready: frame base, row
// pitch, screen width and height, pixel format. The user must write it only
// while no item is in flight; the block does not enforce this. Items pass the
// scan register, then the result register. Throughput is one item per cycle
// unless the receiver stalls, set by the scan position update, which completes
// in the cycle an item is accepted. When the receiver stalls, the result
// register holds and the scan register fills; input ready drops only once both
// are occupied. Reset clears the engine to idle and the registers to their
// defaults: base 0, pitch 4096, 1024 by 768 pixels, 32 bits per pixel.
module rect_circle_fill_engine #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x, pos_y, size_w, size_h, radius, color (low to high)
  input  logic [((2*COORD_BITS+79+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [1:0]             s_axis_tuser,
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // write_address, write_data, byte_enables (low to high)
  output logic [87:0]            m_axis_tdata,
  // write_enable
  output logic                   m_axis_tuser,
  // done_res
  output logic                   m_axis_tlast,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [47:0]            cfg_data_i
);
  import rcf_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned EW    = ((CB > 16) ? CB : 16) + 2;
  localparam int unsigned IN_W  = ((2*CB+79+7)/8)*8;
  localparam int unsigned PAD_W = IN_W - (2*CB+79);

  // ---------------- configuration registers ----------------
  logic [ADDR_W-1:0]  base_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [SCR_W-1:0]   scr_w_q, scr_h_q;
  logic               fmt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pitch_q <= 16'd4096;
      scr_w_q <= 13'd1024;
      scr_h_q <= 13'd768;
      fmt_q   <= FMT_32BPP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_BASE:    base_q  <= cfg_data_i;
        REG_ROW_PITCH:     pitch_q <= cfg_data_i[PITCH_W-1:0];
        REG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i[SCR_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i[SCR_W-1:0];
        REG_PIXEL_FORMAT:  fmt_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- input unpacking ----------------
  logic signed [CB-1:0] pos_x, pos_y;
  logic [15:0]          size_w, size_h;
  logic [RAD_W-1:0]     radius;
  logic [DATA_W-1:0]    color;
  logic [PAD_W:0]       pad_unused;
  func_e                func;

  assign pos_x      = s_axis_tdata[CB-1:0];
  assign pos_y      = s_axis_tdata[2*CB-1:CB];
  assign size_w     = s_axis_tdata[2*CB+15:2*CB];
  assign size_h     = s_axis_tdata[2*CB+31:2*CB+16];
  assign radius     = s_axis_tdata[2*CB+46:2*CB+32];
  assign color      = s_axis_tdata[2*CB+78:2*CB+47];
  assign pad_unused = {1'b0, s_axis_tdata[IN_W-1:2*CB+79]};
  assign func       = func_e'(s_axis_tuser);

  // ---------------- pipeline handshake ----------------
  logic job_vld_q, res_vld_q;
  logic out_free, accept;

  assign out_free      = !res_vld_q || m_axis_tready;
  assign s_axis_tready = !job_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------- start: clip the bounding box ----------------
  logic signed [EW-1:0] px_e, py_e, r_e;
  logic signed [EW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [EW-1:0] c0, c1, r0, r1, sw_e, sh_e;
  logic                 box_ok;
  logic                 is_start, is_circle;
  logic [29:0]          rsq_new;

  assign is_start  = (func == FUNC_RECT) || (func == FUNC_CIRCLE);
  assign is_circle = (func == FUNC_CIRCLE);
  assign px_e      = {{(EW-CB){pos_x[CB-1]}}, pos_x};
  assign py_e      = {{(EW-CB){pos_y[CB-1]}}, pos_y};
  assign r_e       = {{(EW-RAD_W){1'b0}}, radius};
  assign sw_e      = {{(EW-SCR_W){1'b0}}, scr_w_q};
  assign sh_e      = {{(EW-SCR_W){1'b0}}, scr_h_q};
  assign rsq_new   = {15'd0, radius} * {15'd0, radius};

  always_comb begin
    if (is_circle) begin
      lo_x = px_e - r_e;
      hi_x = px_e + r_e + EW'(1);
      lo_y = py_e - r_e;
      hi_y = py_e + r_e + EW'(1);
    end else begin
      lo_x = px_e;
      hi_x = px_e + {{(EW-16){1'b0}}, size_w};
      lo_y = py_e;
      hi_y = py_e + {{(EW-16){1'b0}}, size_h};
    end
    c0     = (lo_x < 0) ? '0 : lo_x;
    r0     = (lo_y < 0) ? '0 : lo_y;
    c1     = (hi_x > sw_e) ? sw_e : hi_x;
    r1     = (hi_y > sh_e) ? sh_e : hi_y;
    box_ok = (c0 < c1) && (r0 < r1);
  end

  // ---------------- scan state ----------------
  logic                 busy_q, busy_d;
  logic                 circ_q, circ_d;
  logic [SCR_W-1:0]     col_q, col_d, row_q, row_d;
  logic [SCR_W-1:0]     first_q, first_d, end_c_q, end_c_d, end_r_q, end_r_d;
  logic signed [CB-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [RSQ_W-1:0]     rsq_q, rsq_d;
  logic [DATA_W-1:0]    fill_q, fill_d;
  logic [SCR_W:0]       col_inc, row_inc;
  logic signed [EW-1:0] dx_full, dy_full;
  job_t                 job_q, job_d;

  assign col_inc = {1'b0, col_q} + 14'd1;
  assign row_inc = {1'b0, row_q} + 14'd1;
  assign dx_full = {{(EW-SCR_W){1'b0}}, col_q} - {{(EW-CB){cx_q[CB-1]}}, cx_q};
  assign dy_full = {{(EW-SCR_W){1'b0}}, row_q} - {{(EW-CB){cy_q[CB-1]}}, cy_q};

  always_comb begin
    busy_d  = busy_q;
    circ_d  = circ_q;
    col_d   = col_q;
    row_d   = row_q;
    first_d = first_q;
    end_c_d = end_c_q;
    end_r_d = end_r_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    rsq_d   = rsq_q;
    fill_d  = fill_q;
    job_d        = '0;
    job_d.circle = circ_q;
    job_d.col    = col_q;
    job_d.row    = row_q;
    job_d.dx     = dx_full[OFS_W-1:0];
    job_d.dy     = dy_full[OFS_W-1:0];
    job_d.rsq    = rsq_q;
    job_d.color  = fill_q;
    if (is_start) begin
      // load the shape; the box registers change only when it is not empty
      circ_d     = is_circle;
      fill_d     = color;
      cx_d       = pos_x;
      cy_d       = pos_y;
      rsq_d      = is_circle ? rsq_new : '0;
      busy_d     = box_ok;
      job_d.done = !box_ok;
      if (box_ok) begin
        first_d = c0[SCR_W-1:0];
        col_d   = c0[SCR_W-1:0];
        row_d   = r0[SCR_W-1:0];
        end_c_d = c1[SCR_W-1:0];
        end_r_d = r1[SCR_W-1:0];
      end
    end else if (!busy_q) begin
      job_d.done = 1'b1;
    end else begin
      // step: hand this position on, then move to the next one
      job_d.cand = 1'b1;
      if (col_inc < {1'b0, end_c_q}) begin
        col_d = col_inc[SCR_W-1:0];
      end else if (row_inc < {1'b0, end_r_q}) begin
        col_d = first_q;
        row_d = row_inc[SCR_W-1:0];
      end else begin
        busy_d     = 1'b0;
        job_d.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      circ_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      first_q <= '0;
      end_c_q <= '0;
      end_r_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      rsq_q   <= '0;
      fill_q  <= '0;
    end else if (accept) begin
      busy_q  <= busy_d;
      circ_q  <= circ_d;
      col_q   <= col_d;
      row_q   <= row_d;
      first_q <= first_d;
      end_c_q <= end_c_d;
      end_r_q <= end_r_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      rsq_q   <= rsq_d;
      fill_q  <= fill_d;
    end
  end

  // ---------------- scan register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      job_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  // ---------------- pixel stage and result register ----------------
  pix_cfg_t pix_cfg;
  result_t  res_d, res_q;

  assign pix_cfg.base  = base_q;
  assign pix_cfg.pitch = pitch_q;
  assign pix_cfg.fmt   = fmt_q;

  rcf_pixel_calc u_pixel (
    .job_i (job_q),
    .cfg_i (pix_cfg),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_free) begin
      res_vld_q <= job_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && job_vld_q) begin
      res_q <= res_d;
    end
  end

  // Pad bits of the input bus carry nothing.
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {4'h0, res_q.be, res_q.data, res_q.addr}
                         | {87'd0, &pad_unused & 1'b0};
  assign m_axis_tuser  = res_q.we;
  assign m_axis_tlast  = res_q.done;

endmodule

// ===== tb/rect_circle_fill_engine_tb.sv =====
// Self-checking testbench for the rectangle and circle fill engine.
module rect_circle_fill_engine_tb;
  import rcf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;

  // Predicts the write stream from accepted items and checks each result item.
  class fill_checker;
    logic [47:0] base;
    logic [15:0] pitch;
    logic [12:0] scr_w;
    logic [12:0] scr_h;
    logic        fmt;

    bit          busy;
    bit          circ;
    int unsigned col;
    int unsigned row;
    int unsigned first_col;
    int unsigned end_col;
    int unsigned end_row;
    longint      centre_x;
    longint      centre_y;
    longint unsigned rsq;
    logic [31:0] fill;

    result_t     pending_writes[$];
    int unsigned err_count;
    int unsigned n_checked;
    int unsigned n_writes;

    function new();
      base = '0;
      pitch = 16'd4096;
      scr_w = 13'd1024;
      scr_h = 13'd768;
      fmt = FMT_32BPP;
      busy = 0;
      circ = 0;
      col = 0;
      row = 0;
      first_col = 0;
      end_col = 0;
      end_row = 0;
      centre_x = 0;
      centre_y = 0;
      rsq = 0;
      fill = '0;
      err_count = 0;
      n_checked = 0;
      n_writes = 0;
    endfunction

    task report_mismatch(input string what);
      err_count++;
      $display("mismatch at result %0d (t=%0t): %s", n_checked, $time, what);
    endtask

    function void cfg_write(input logic [2:0] idx, input logic [47:0] val);
      case (idx)
        REG_FRAME_BASE:    base = val;
        REG_ROW_PITCH:     pitch = val[15:0];
        REG_SCREEN_WIDTH:  scr_w = val[12:0];
        REG_SCREEN_HEIGHT: scr_h = val[12:0];
        REG_PIXEL_FORMAT:  fmt = val[0];
        default: ;
      endcase
    endfunction

    // Clip [c0,c1) x [r0,r1) to the screen; returns 1 if anything is left.
    function bit load_box(input longint c0, input longint c1,
                          input longint r0, input longint r1);
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 > longint'(scr_w)) c1 = longint'(scr_w);
      if (r1 > longint'(scr_h)) r1 = longint'(scr_h);
      if (c0 >= c1 || r0 >= r1) return 0;
      first_col = int'(c0);
      end_col = int'(c1);
      end_row = int'(r1);
      col = first_col;
      row = int'(r0);
      return 1;
    endfunction

    // Positions still to scan in the current shape.
    function int unsigned remaining();
      if (!busy) return 0;
      return (end_row - row - 1) * (end_col - first_col) + (end_col - col);
    endfunction

    function void note_item(input func_e f, input logic signed [15:0] px,
                            input logic signed [15:0] py, input logic [15:0] w,
                            input logic [15:0] h, input logic [14:0] r,
                            input logic [31:0] color);
      result_t         e;
      longint          sx;
      longint          sy;
      longint          lr;
      longint          dx;
      longint          dy;
      longint unsigned addr;
      bit              keep;
      e = '0;
      sx = longint'(px);
      sy = longint'(py);
      lr = longint'(r);
      if (f == FUNC_RECT || f == FUNC_CIRCLE) begin
        circ = (f == FUNC_CIRCLE);
        fill = color;
        centre_x = sx;
        centre_y = sy;
        if (circ) begin
          rsq = longint'(lr * lr);
          busy = load_box(sx - lr, sx + lr + 1, sy - lr, sy + lr + 1);
        end else begin
          rsq = 0;
          busy = load_box(sx, sx + longint'(w), sy, sy + longint'(h));
        end
        e.done = !busy;
      end else if (!busy) begin
        e.done = 1'b1;
      end else begin
        keep = 1;
        if (circ) begin
          dx = longint'(col) - centre_x;
          dy = longint'(row) - centre_y;
          keep = longint'(dx * dx + dy * dy) <= longint'(rsq);
        end
        if (keep) begin
          addr = longint'(base) + longint'(row) * longint'(pitch)
               + longint'(col) * ((fmt == FMT_32BPP) ? 4 : 3);
          e.we = 1'b1;
          e.addr = addr[47:0];
          e.data = (fmt == FMT_32BPP) ? fill : {8'h00, fill[23:0]};
          e.be = (fmt == FMT_32BPP) ? BE_32BPP : BE_24BPP;
        end
        // advance left to right, then row by row
        if (col + 1 < end_col) begin
          col++;
        end else if (row + 1 < end_row) begin
          col = first_col;
          row++;
        end else begin
          busy = 0;
          e.done = 1'b1;
        end
      end
      pending_writes.push_back(e);
    endfunction

    task check_result(input logic we, input logic [87:0] d, input logic done);
      result_t e;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected result we=%0b done=%0b", we, done));
        return;
      end
      e = pending_writes.pop_front();
      n_checked++;
      if (e.we) n_writes++;
      if (we !== e.we)
        report_mismatch($sformatf("write_enable %0b, expected %0b", we, e.we));
      if (d[47:0] !== e.addr)
        report_mismatch($sformatf("address %h, expected %h", d[47:0], e.addr));
      if (d[79:48] !== e.data)
        report_mismatch($sformatf("data %h, expected %h", d[79:48], e.data));
      if (d[83:80] !== e.be)
        report_mismatch($sformatf("byte enables %h, expected %h", d[83:80], e.be));
      if (done !== e.done)
        report_mismatch($sformatf("done %0b, expected %0b", done, e.done));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [47:0]  cfg_data_i = '0;

  fill_checker  sb = new();
  int unsigned  cycles = 0;
  int unsigned  n_items = 0;
  int unsigned  n_shapes = 0;
  bit           gapless = 0;
  bit           hold_req = 0;

  rect_circle_fill_engine #(.COORD_BITS(16)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  function automatic int unsigned draw_gap();
    return gapless ? 0 : $urandom_range(0, 11);
  endfunction

  // Receiver: random wait per item, one long hold-off on request
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_req = 0;
      end
      g = draw_gap();
      if (g != 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Offer one item; entered and left at a falling edge.
  task automatic send_item(input func_e f, input logic signed [15:0] px,
                           input logic signed [15:0] py, input logic [15:0] w,
                           input logic [15:0] h, input logic [14:0] r,
                           input logic [31:0] color);
    int unsigned g;
    g = draw_gap();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tuser <= f;
    s_axis_tdata <= {1'b0, color, r, h, w, py, px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(f, px, py, w, h, r, color);
    n_items++;
    if (f == FUNC_RECT || f == FUNC_CIRCLE) n_shapes++;
    @(negedge clk_i);
  endtask

  // Step items carry random junk in the unused fields.
  task automatic send_steps(input int unsigned n);
    repeat (n)
      send_item(($urandom_range(0, 7) == 0) ? FUNC_STEP_X : FUNC_STEP,
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom), $urandom);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.cfg_write(idx, val);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input int phase);
    logic [47:0] b;
    b = 48'({$urandom, $urandom});
    case (phase)
      1: begin
        write_reg(REG_FRAME_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_ROW_PITCH, 48'hFFFF);
        write_reg(REG_SCREEN_WIDTH, 48'd4096);
        write_reg(REG_SCREEN_HEIGHT, 48'd4096);
        write_reg(REG_PIXEL_FORMAT, 48'd1);
      end
      2: begin
        write_reg(REG_FRAME_BASE, 48'd0);
        write_reg(REG_ROW_PITCH, 48'd0);
        write_reg(REG_SCREEN_WIDTH, 48'd0);
        write_reg(REG_SCREEN_HEIGHT, 48'd4096);
        write_reg(REG_PIXEL_FORMAT, 48'd0);
      end
      4: begin
        write_reg(REG_FRAME_BASE, b);
        write_reg(REG_ROW_PITCH, 48'($urandom_range(0, 65535)));
        write_reg(REG_SCREEN_WIDTH, 48'd4096);
        write_reg(REG_SCREEN_HEIGHT, 48'd0);
        write_reg(REG_PIXEL_FORMAT, 48'd1);
      end
      default: begin
        write_reg(REG_FRAME_BASE, b);
        write_reg(REG_ROW_PITCH, 48'($urandom_range(0, 65535)));
        write_reg(REG_SCREEN_WIDTH, 48'($urandom_range(1, 48)));
        write_reg(REG_SCREEN_HEIGHT, 48'($urandom_range(1, 40)));
        write_reg(REG_PIXEL_FORMAT, 48'($urandom_range(0, 1)));
      end
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // One shape: mostly a start near the screen followed by its scan, sometimes cut short.
  task automatic random_shape();
    int unsigned kind;
    int unsigned n;
    int unsigned sw;
    int unsigned sh;
    logic signed [15:0] px;
    logic signed [15:0] py;
    kind = $urandom_range(0, 9);
    sw = 32'(sb.scr_w);
    sh = 32'(sb.scr_h);
    gapless = ($urandom_range(0, 4) == 0);
    if (kind == 0) begin
      // noise: any func, any field values
      send_item(func_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 15'($urandom), $urandom);
      send_steps($urandom_range(0, 3));
    end else begin
      px = 16'(int'($urandom_range(0, sw + 16)) - 8);
      py = 16'(int'($urandom_range(0, sh + 16)) - 8);
      if (kind < 6)
        send_item(FUNC_RECT, px, py, 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 12)), 15'($urandom), $urandom);
      else
        send_item(FUNC_CIRCLE, px, py, 16'($urandom), 16'($urandom),
                  15'($urandom_range(0, 6)), $urandom);
      n = sb.remaining();
      if (n > 150) n = $urandom_range(1, 20);
      // sometimes cut the scan short, otherwise run to the end or up to two steps past it
      if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
      else n = n + $urandom_range(0, 2);
      send_steps(n);
    end
  endtask

  initial begin
    int unsigned start;
    int unsigned len;
    bit          stall_done;
    stall_done = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed items at reset defaults
    send_item(FUNC_RECT, 16'sd0, 16'sd0, 16'd2, 16'd2, 15'd0, 32'hFFFF_FFFF);
    send_steps(4);
    send_steps(1);                       // step while idle
    // negative origin is clipped, not wrapped
    send_item(FUNC_RECT, -16'sd1, -16'sd2, 16'd3, 16'd3, 15'h7FFF, 32'h0);
    send_steps(2);
    // circle at the corner: one box position outside the radius
    send_item(FUNC_CIRCLE, 16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF, 15'd1, 32'h1234_5678);
    send_steps(4);
    send_item(FUNC_CIRCLE, 16'sd3, 16'sd3, 16'd0, 16'd0, 15'd0, 32'h00C0_FFEE);
    send_steps(1);
    // empty shapes: zero width, zero height, off screen
    send_item(FUNC_RECT, 16'sd5, 16'sd5, 16'd0, 16'd4, 15'd0, 32'h5555_5555);
    send_item(FUNC_RECT, 16'sd5, 16'sd5, 16'd4, 16'd0, 15'd0, 32'hAAAA_AAAA);
    send_item(FUNC_RECT, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 15'd0, 32'h0);
    // full-screen rectangle, abandoned by a new start
    send_item(FUNC_RECT, -16'sh8000, -16'sh8000, 16'hFFFF, 16'hFFFF, 15'd0, 32'hA5A5_A5A5);
    send_item(FUNC_STEP_X, 16'h0, 16'h0, 16'h0, 16'h0, 15'h0, 32'h0);
    send_item(FUNC_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 32'hFFFF_FFFF);
    send_item(FUNC_CIRCLE, 16'sd1023, 16'sd767, 16'd0, 16'd0, 15'h7FFF, 32'h0F0F_0F0F);
    send_steps(1);
    send_item(FUNC_RECT, 16'sd1023, 16'sd767, 16'd1, 16'd1, 15'd0, 32'hDEAD_BEEF);
    send_steps(1);

    // Random shapes over several register settings
    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        drain();
        configure(phase);
      end
      len = (phase == 0) ? 150 : ((phase == 2 || phase == 4) ? 60 : 240);
      start = n_items;
      while (n_items - start < len) begin
        if (phase == 3 && !stall_done && n_items - start > 100) begin
          hold_req = 1;
          stall_done = 1;
        end
        random_shape();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("%0d items in %0d shapes over 8 register settings", n_items, n_shapes);
    $display("%0d results checked, %0d of them pixel writes, %0d mismatches",
             sb.n_checked, sb.n_writes, sb.err_count);
    if (sb.err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/rcf_pkg.sv
src/rcf_pixel_calc.sv
src/rect_circle_fill_engine.sv
tb/rect_circle_fill_engine_tb.sv
